/* sv/button_debounce_autorepeat_unit_macros.svh */
// Assertion macros shared by the debounce/auto-repeat RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_UNIT_MACROS_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BDA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bda assertion failed");

// Next-cycle implication, disabled during reset.
`define BDA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bda assertion failed");

`endif

/* sv/bda_pkg.sv */
// Types and constants for the debounce/auto-repeat unit.
// No dependencies; imported by bda_fsm and the top level.
package bda_pkg;

  localparam int unsigned CntW = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CntW-1:0] CntMax = 6'd63;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PRESS_BOUNCE   = 3'd0,
    REG_RELEASE_BOUNCE = 3'd1,
    REG_POLL_INTERVAL  = 3'd2,
    REG_HOLD_REPEAT    = 3'd3,
    REG_REPEAT_PERIOD  = 3'd4
  } cfg_reg_t;

  localparam logic OP_PRESS = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [CntW-1:0] PressBounceRst   = 6'd4;
  localparam logic [CntW-1:0] ReleaseBounceRst = 6'd4;
  localparam logic [CntW-1:0] PollIntervalRst  = 6'd2;
  localparam logic [CntW-1:0] HoldRepeatRst    = 6'd20;
  localparam logic [CntW-1:0] RepeatPeriodRst  = 6'd11;

  typedef struct packed {
    logic operation;
    logic button_id;
    logic still_pressed;
  } in_item_t;

  typedef struct packed {
    logic repeat_left;
    logic repeat_right;
    logic rearm;
    logic busy_res;
  } out_item_t;

  typedef struct packed {
    logic [CntW-1:0] press_bounce_ticks;
    logic [CntW-1:0] release_bounce_ticks;
    logic [CntW-1:0] poll_interval_ticks;
    logic [CntW-1:0] hold_before_repeat;
    logic [CntW-1:0] repeat_period_ticks;
  } cfg_t;

endpackage

/* sv/button_debounce_autorepeat_unit.sv */
// Top level of the push-button debounce/auto-repeat unit.
// Depends on bda_pkg, bda_fsm and button_debounce_autorepeat_unit_macros.svh.
//
// Takes one press or tick transaction per clock while in_stall is low and
// returns exactly one result transaction for each. The phase update is a single
// register stage in bda_fsm; results go to an output register backed by a
// one-entry skid register, so input is accepted every cycle and in_stall rises
// only once a stalled output has both the output and skid registers full. Write
// configuration only while no result is outstanding.
`include "button_debounce_autorepeat_unit_macros.svh"
module button_debounce_autorepeat_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bda_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bda_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [bda_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [bda_pkg::CntW-1:0]       cfg_data
);
  import bda_pkg::*;

  cfg_t      cfg_r;
  out_item_t step_res;
  out_item_t out_r, out_nxt;
  out_item_t skid_r, skid_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  logic      in_accept;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  bda_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_accept),
    .step_item (in_data),
    .cfg       (cfg_r),
    .step_res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_bounce_ticks   <= PressBounceRst;
      cfg_r.release_bounce_ticks <= ReleaseBounceRst;
      cfg_r.poll_interval_ticks  <= PollIntervalRst;
      cfg_r.hold_before_repeat   <= HoldRepeatRst;
      cfg_r.repeat_period_ticks  <= RepeatPeriodRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRESS_BOUNCE:   cfg_r.press_bounce_ticks   <= cfg_data;
        REG_RELEASE_BOUNCE: cfg_r.release_bounce_ticks <= cfg_data;
        REG_POLL_INTERVAL:  cfg_r.poll_interval_ticks  <= cfg_data;
        REG_HOLD_REPEAT:    cfg_r.hold_before_repeat   <= cfg_data;
        REG_REPEAT_PERIOD:  cfg_r.repeat_period_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || !out_stall) begin
      out_nxt        = skid_valid_r ? skid_r : step_res;
      out_valid_nxt  = skid_valid_r || in_accept;
      skid_valid_nxt = 1'b0;
    end else if (in_accept) begin
      skid_nxt       = step_res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  `BDA_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `BDA_ASSERT_NXT(a_stalled_fill_skid, clk, rst_n,
                  out_valid_r && out_stall && in_accept, skid_valid_r)

endmodule

/* sv/bda_fsm.sv */
// Phase machine and saturating counters of the debounce/auto-repeat unit.
// Depends on bda_pkg and button_debounce_autorepeat_unit_macros.svh.
`include "button_debounce_autorepeat_unit_macros.svh"
module bda_fsm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  bda_pkg::in_item_t step_item,
  input  bda_pkg::cfg_t     cfg,
  output bda_pkg::out_item_t step_res
);
  import bda_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESS   = 2'd1,
    PH_POLL    = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic            handling_r, handling_nxt;
  logic            held_r, held_nxt;
  logic [CntW-1:0] phase_ticks_r, phase_ticks_nxt;
  logic [CntW-1:0] repeat_ticks_r, repeat_ticks_nxt;
  logic            repeating_r, repeating_nxt;
  logic            rep, rearm;

  always_comb begin
    phase_nxt        = phase_r;
    handling_nxt     = handling_r;
    held_nxt         = held_r;
    phase_ticks_nxt  = phase_ticks_r;
    repeat_ticks_nxt = repeat_ticks_r;
    repeating_nxt    = repeating_r;
    rep              = 1'b0;
    rearm            = 1'b0;
    if (step_item.operation == OP_PRESS) begin
      if (!handling_r) begin
        held_nxt        = step_item.button_id;
        handling_nxt    = 1'b1;
        phase_ticks_nxt = '0;
        phase_nxt       = PH_PRESS;
      end
    end else if (handling_r) begin
      if (phase_ticks_r != CntMax) phase_ticks_nxt = phase_ticks_r + 1'b1;
      if (repeat_ticks_r != CntMax) repeat_ticks_nxt = repeat_ticks_r + 1'b1;
      unique case (phase_r)
        PH_IDLE: begin
          phase_ticks_nxt = '0;
          phase_nxt       = PH_PRESS;
        end
        PH_PRESS: begin
          if (phase_ticks_nxt >= cfg.press_bounce_ticks) begin
            phase_ticks_nxt = '0;
            phase_nxt       = PH_POLL;
          end
        end
        PH_POLL: begin
          if (phase_ticks_nxt >= cfg.poll_interval_ticks) begin
            if (!step_item.still_pressed) begin
              phase_ticks_nxt  = '0;
              repeat_ticks_nxt = '0;
              repeating_nxt    = 1'b0;
              phase_nxt        = PH_RELEASE;
            end
            if (repeat_ticks_nxt == cfg.hold_before_repeat) begin
              repeat_ticks_nxt = '0;
              repeating_nxt    = 1'b1;
              rep              = 1'b1;
            end
            if (repeating_nxt && repeat_ticks_nxt == cfg.repeat_period_ticks) begin
              repeat_ticks_nxt = '0;
              rep              = 1'b1;
            end
          end
        end
        PH_RELEASE: begin
          if (phase_ticks_nxt >= cfg.release_bounce_ticks) begin
            rearm           = 1'b1;
            handling_nxt    = 1'b0;
            phase_nxt       = PH_IDLE;
            phase_ticks_nxt = '0;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    step_res.repeat_left  = rep & ~held_nxt;
    step_res.repeat_right = rep & held_nxt;
    step_res.rearm        = rearm;
    step_res.busy_res     = handling_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      handling_r     <= 1'b0;
      held_r         <= 1'b0;
      phase_ticks_r  <= '0;
      repeat_ticks_r <= '0;
      repeating_r    <= 1'b0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      handling_r     <= handling_nxt;
      held_r         <= held_nxt;
      phase_ticks_r  <= phase_ticks_nxt;
      repeat_ticks_r <= repeat_ticks_nxt;
      repeating_r    <= repeating_nxt;
    end
  end

  `BDA_ASSERT_IMP(a_idle_when_free, clk, rst_n, !handling_r,
                  phase_r == PH_IDLE && phase_ticks_r == '0)
  `BDA_ASSERT_NXT(a_rearm_goes_idle, clk, rst_n, step_en && step_res.rearm,
                  phase_r == PH_IDLE && !handling_r)
  `BDA_ASSERT_NXT(a_idle_tick_holds, clk, rst_n,
                  step_en && step_item.operation == OP_TICK && !handling_r,
                  $stable(repeat_ticks_r) && $stable(repeating_r))

endmodule

/* test/tb_top.sv */
// Self-checking testbench for button_debounce_autorepeat_unit: press/tick transactions in,
// one result transaction out per item, checked against an in-bench debounce predictor.
// Depends on bda_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_top;
  import bda_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [CfgIdxW-1:0] UNUSED_REG_INDEX = 3'd7;

  localparam cfg_t DEFAULT_TIMING = '{PressBounceRst, ReleaseBounceRst, PollIntervalRst,
                                      HoldRepeatRst, RepeatPeriodRst};
  localparam cfg_t SHORT_TIMING = '{6'd1, 6'd1, 6'd0, 6'd2, 6'd1};
  localparam cfg_t MIN_TIMING   = '{6'd1, 6'd1, 6'd0, 6'd1, 6'd1};
  localparam cfg_t MAX_TIMING   = '{CntMax, CntMax, CntMax, CntMax, CntMax};

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PRESS_BOUNCE,
    PH_POLL,
    PH_RELEASE_BOUNCE
  } debounce_phase_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;
  logic       cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CntW-1:0]    cfg_data;

  // predictor state and its copy of the timing registers
  cfg_t              dbn_cfg;
  debounce_phase_t   dbn_phase;
  logic              dbn_busy;
  logic              dbn_button;
  logic [CntW-1:0]   dbn_phase_ticks;
  logic [CntW-1:0]   dbn_repeat_ticks;
  logic              dbn_repeating;

  out_item_t   pending_results[$];
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned cycle_count;
  bit          tx_idle_en;
  bit          rx_idle_en;

  button_debounce_autorepeat_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL button_debounce_autorepeat_unit");
      $finish;
    end
  end

  function automatic out_item_t predict_debounce(in_item_t item);
    out_item_t res;
    logic      fire;
    logic      rearm_now;
    res = '0;
    fire = 1'b0;
    rearm_now = 1'b0;
    if (item.operation == OP_PRESS) begin
      if (!dbn_busy) begin
        dbn_button = item.button_id;
        dbn_busy = 1'b1;
        dbn_phase_ticks = '0;
        dbn_phase = PH_PRESS_BOUNCE;
      end
    end else if (dbn_busy) begin
      dbn_phase_ticks = (dbn_phase_ticks == CntMax) ? CntMax : dbn_phase_ticks + 1'b1;
      dbn_repeat_ticks = (dbn_repeat_ticks == CntMax) ? CntMax : dbn_repeat_ticks + 1'b1;
      case (dbn_phase)
        PH_IDLE: begin
          dbn_phase_ticks = '0;
          dbn_phase = PH_PRESS_BOUNCE;
        end
        PH_PRESS_BOUNCE: begin
          if (dbn_phase_ticks >= dbn_cfg.press_bounce_ticks) begin
            dbn_phase_ticks = '0;
            dbn_phase = PH_POLL;
          end
        end
        PH_POLL: begin
          if (dbn_phase_ticks >= dbn_cfg.poll_interval_ticks) begin
            if (!item.still_pressed) begin
              dbn_phase_ticks = '0;
              dbn_repeat_ticks = '0;
              dbn_repeating = 1'b0;
              dbn_phase = PH_RELEASE_BOUNCE;
            end
            if (dbn_repeat_ticks == dbn_cfg.hold_before_repeat) begin
              dbn_repeat_ticks = '0;
              dbn_repeating = 1'b1;
              fire = 1'b1;
            end
            if (dbn_repeating && dbn_repeat_ticks == dbn_cfg.repeat_period_ticks) begin
              dbn_repeat_ticks = '0;
              fire = 1'b1;
            end
          end
        end
        default: begin
          if (dbn_phase_ticks >= dbn_cfg.release_bounce_ticks) begin
            rearm_now = 1'b1;
            dbn_busy = 1'b0;
            dbn_phase = PH_IDLE;
            dbn_phase_ticks = '0;
          end
        end
      endcase
    end
    res.repeat_left = fire && !dbn_button;
    res.repeat_right = fire && dbn_button;
    res.rearm = rearm_now;
    res.busy_res = dbn_busy;
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with none expected: %p", out_data);
        error_count++;
      end else begin
        exp_item = pending_results.pop_front();
        if (out_data.repeat_left !== exp_item.repeat_left) begin
          $error("repeat_left: expected %0b, got %0b", exp_item.repeat_left, out_data.repeat_left);
          error_count++;
        end
        if (out_data.repeat_right !== exp_item.repeat_right) begin
          $error("repeat_right: expected %0b, got %0b", exp_item.repeat_right,
                 out_data.repeat_right);
          error_count++;
        end
        if (out_data.rearm !== exp_item.rearm) begin
          $error("rearm: expected %0b, got %0b", exp_item.rearm, out_data.rearm);
          error_count++;
        end
        if (out_data.busy_res !== exp_item.busy_res) begin
          $error("busy_res: expected %0b, got %0b", exp_item.busy_res, out_data.busy_res);
          error_count++;
        end
      end
    end
  end

  // receiver back-pressure
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic in_item_t make_item(logic op, logic btn, logic pressed);
    in_item_t item;
    item.operation = op;
    item.button_id = btn;
    item.still_pressed = pressed;
    return item;
  endfunction

  // Entered and left at a falling edge; valid stays high after the transaction.
  task automatic send_item(input in_item_t item);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_debounce(item));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic pause_input();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic apply_timing(input cfg_t c);
    pause_input();
    cfg_we <= 1'b1;
    cfg_index <= REG_PRESS_BOUNCE;   cfg_data <= c.press_bounce_ticks;   @(negedge clk);
    cfg_index <= REG_RELEASE_BOUNCE; cfg_data <= c.release_bounce_ticks; @(negedge clk);
    cfg_index <= REG_POLL_INTERVAL;  cfg_data <= c.poll_interval_ticks;  @(negedge clk);
    cfg_index <= REG_HOLD_REPEAT;    cfg_data <= c.hold_before_repeat;   @(negedge clk);
    cfg_index <= REG_REPEAT_PERIOD;  cfg_data <= c.repeat_period_ticks;  @(negedge clk);
    cfg_we <= 1'b0;
    dbn_cfg = c;
  endtask

  function automatic logic [CntW-1:0] pick_ticks(int unsigned low);
    case ($urandom_range(0, 3))
      0: return CntW'(low);
      1: return CntMax;
      default: return CntW'($urandom_range(low, 15));
    endcase
  endfunction

  // One press/hold/release cycle with random content, or a burst of noise.
  task automatic run_press_sequence();
    int unsigned held;
    int unsigned released;
    int unsigned span;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6))
        send_item(make_item(rand_bit(), rand_bit(), rand_bit()));
      return;
    end
    span = dbn_cfg.press_bounce_ticks + dbn_cfg.poll_interval_ticks +
           dbn_cfg.hold_before_repeat + 2 * dbn_cfg.repeat_period_ticks + 4;
    held = $urandom_range(0, span);
    send_item(make_item(OP_PRESS, rand_bit(), rand_bit()));
    repeat (held) begin
      if ($urandom_range(0, 24) == 0)
        send_item(make_item(OP_PRESS, rand_bit(), rand_bit()));
      else
        send_item(make_item(OP_TICK, rand_bit(), $urandom_range(0, 29) != 0));
    end
    if ($urandom_range(0, 5) == 0)
      released = $urandom_range(0, dbn_cfg.release_bounce_ticks);
    else
      released = dbn_cfg.release_bounce_ticks + $urandom_range(1, 3);
    repeat (released)
      send_item(make_item(OP_TICK, rand_bit(), $urandom_range(0, 3) == 0));
    repeat ($urandom_range(0, 2))
      send_item(make_item(OP_TICK, rand_bit(), rand_bit()));
  endtask

  task automatic run_random_sequences(input int unsigned budget, input bit allow_idle);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < budget) begin
      tx_idle_en = allow_idle && $urandom_range(0, 2) != 0;
      rx_idle_en = allow_idle && $urandom_range(0, 2) != 0;
      run_press_sequence();
    end
    rx_idle_en = 1'b0;
  endtask

  task automatic test_default_timing();
    run_random_sequences(100, 1'b1);
  endtask

  // idle ticks, busy presses, repeats for both buttons, release and rearm
  task automatic test_directed_short_timing();
    apply_timing(SHORT_TIMING);
    tx_idle_en = 1'b0;
    send_item(make_item(OP_TICK, 1'b1, 1'b1));
    send_item(make_item(OP_TICK, 1'b0, 1'b0));
    send_item(make_item(OP_PRESS, 1'b1, 1'b0));
    send_item(make_item(OP_PRESS, 1'b0, 1'b1));
    repeat (4) send_item(make_item(OP_TICK, 1'b0, 1'b1));
    send_item(make_item(OP_TICK, 1'b1, 1'b0));
    send_item(make_item(OP_TICK, 1'b0, 1'b1));
    send_item(make_item(OP_TICK, 1'b1, 1'b1));
    send_item(make_item(OP_PRESS, 1'b0, 1'b0));
    repeat (5) send_item(make_item(OP_TICK, 1'b1, 1'b1));
    send_item(make_item(OP_TICK, 1'b0, 1'b0));
    send_item(make_item(OP_TICK, 1'b1, 1'b0));
    send_item(make_item(OP_PRESS, 1'b1, 1'b1));
    send_item(make_item(OP_TICK, 1'b0, 1'b1));
  endtask

  task automatic test_minimum_timing();
    apply_timing(MIN_TIMING);
    run_random_sequences(100, 1'b1);
  endtask

  task automatic test_maximum_timing();
    apply_timing(MAX_TIMING);
    run_random_sequences(40, 1'b1);
  endtask

  task automatic test_unused_register_index();
    cfg_t c;
    c = '{pick_ticks(1), pick_ticks(1), pick_ticks(0), pick_ticks(1), pick_ticks(1)};
    apply_timing(c);
    pause_input();
    cfg_we <= 1'b1;
    cfg_index <= UNUSED_REG_INDEX;
    cfg_data <= CntW'($urandom_range(0, CntMax));
    @(negedge clk);
    cfg_we <= 1'b0;
    run_random_sequences(100, 1'b1);
  endtask

  task automatic test_mixed_timing_no_idle();
    cfg_t c;
    c = '{pick_ticks(1), pick_ticks(1), pick_ticks(0), pick_ticks(1), pick_ticks(1)};
    apply_timing(c);
    run_random_sequences(100, 1'b0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    error_count = 0;
    items_sent = 0;
    cycle_count = 0;
    dbn_cfg = DEFAULT_TIMING;
    dbn_phase = PH_IDLE;
    dbn_busy = 1'b0;
    dbn_button = 1'b0;
    dbn_phase_ticks = '0;
    dbn_repeat_ticks = '0;
    dbn_repeating = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_default_timing();
    test_directed_short_timing();
    test_minimum_timing();
    test_maximum_timing();
    test_unused_register_index();
    test_mixed_timing_no_idle();

    pause_input();
    repeat (4) @(negedge clk);
    if (error_count == 0)
      $display("PASS button_debounce_autorepeat_unit");
    else
      $display("FAIL button_debounce_autorepeat_unit");
    $finish;
  end

endmodule

/* button_debounce_autorepeat_unit.f */
+incdir+sv
sv/bda_pkg.sv
sv/bda_fsm.sv
sv/button_debounce_autorepeat_unit.sv
test/tb_top.sv
